// ===== rtl/core/ldpm_pkg.sv =====
package ldpm_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int COEFF_FRAC_BITS_DEF = 28;
  localparam int FOCAL_FRAC          = 16;
  localparam int Q_BITS              = 31;
  localparam int CFG_IDX_BITS        = 4;
  localparam int CFG_DATA_BITS       = 64;

  localparam logic [31:0]        FOCAL_RESET = 32'h0001_0000;
  localparam logic signed [31:0] LIM_HI      = 32'sh7fff_ffff;
  localparam logic signed [31:0] LIM_LO      = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FOCAL_X    = 4'd0,
    REG_FOCAL_Y    = 4'd1,
    REG_CENTER_X   = 4'd2,
    REG_CENTER_Y   = 4'd3,
    REG_RADIAL_K1  = 4'd4,
    REG_RADIAL_K2  = 4'd5,
    REG_RADIAL_K3  = 4'd6,
    REG_TANGENTIAL = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sq_t;

  typedef struct packed {
    logic               valid;
    logic               clip;
    logic signed [31:0] val;
  } norm_t;

  // floor((v + 2^(s-1)) / 2^s): nearest, ties toward plus infinity
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int s);
    return (v + (68'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic sq_t sat32(input logic signed [67:0] v);
    sq_t s;
    if (v > 68'sd2147483647) begin
      s.val  = LIM_HI;
      s.clip = 1'b1;
    end else if (v < -68'sd2147483648) begin
      s.val  = LIM_LO;
      s.clip = 1'b1;
    end else begin
      s.val  = v[31:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

  function automatic sq_t rsat(input logic signed [67:0] v, input int s);
    return sat32(rnd(v, s));
  endfunction

endpackage

// ===== rtl/core/ldpm_norm_div.sv =====
module ldpm_norm_div
  import ldpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int NORM_SHIFT = FOCAL_FRAC + COEFF_FRAC_BITS_DEF - COORD_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_pixel,
  input  logic [COORD_BITS-1:0] in_center,
  input  logic [31:0]           focal,
  output norm_t                 norm
);

  localparam int WC = ((COORD_BITS + NORM_SHIFT > 63) ? COORD_BITS + NORM_SHIFT : 63) + 1;

  logic signed [COORD_BITS:0] d;
  logic [COORD_BITS-1:0]      n;
  logic [WC-1:0]              nn;
  logic [WC-1:0]              ff;

  logic                  v_r   [0:Q_BITS];
  logic [31:0]           r_r   [0:Q_BITS];
  logic [Q_BITS-1:0]     q_r   [0:Q_BITS];
  logic [COORD_BITS-1:0] n_r   [0:Q_BITS];
  logic                  neg_r [0:Q_BITS];
  logic                  sat_r [0:Q_BITS];

  logic signed [31:0] mag;
  norm_t              norm_r;

  assign d  = $signed({1'b0, in_pixel}) - $signed({1'b0, in_center});
  assign n  = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
  assign nn = WC'(n) << NORM_SHIFT;
  assign ff = WC'(focal) << Q_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_r[0]   <= 32'(nn >> Q_BITS);
    q_r[0]   <= '0;
    n_r[0]   <= n;
    neg_r[0] <= d[COORD_BITS];
    sat_r[0] <= (nn >= ff);
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    localparam int BI = Q_BITS - 1 - k;
    logic        nb;
    logic [32:0] t;
    logic        ge;

    if (BI >= NORM_SHIFT) begin : g_bit
      assign nb = n_r[k][BI-NORM_SHIFT];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign t  = {r_r[k], nb};
    assign ge = (t >= {1'b0, focal});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      r_r[k+1]   <= ge ? 32'(t - {1'b0, focal}) : t[31:0];
      q_r[k+1]   <= {q_r[k][Q_BITS-2:0], ge};
      n_r[k+1]   <= n_r[k];
      neg_r[k+1] <= neg_r[k];
      sat_r[k+1] <= sat_r[k];
    end
  end

  assign mag = sat_r[Q_BITS] ? LIM_HI : $signed({1'b0, q_r[Q_BITS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r.valid <= 1'b0;
    end else begin
      norm_r.valid <= v_r[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    norm_r.val  <= neg_r[Q_BITS] ? -mag : mag;
    norm_r.clip <= sat_r[Q_BITS];
  end

  assign norm = norm_r;

endmodule

// ===== rtl/core/lens_distortion_point_map_core.sv =====
// brown-conrady point map: k1 k2 k3 radial, p1 p2 tangential
// input: a pixel pair (in_pixel_x, in_pixel_y, unsigned q12.4) is taken at
// each clock edge with start high; busy is always low, so a point may enter
// on every cycle
// output: out_valid is high for one cycle with out_mapped_x, out_mapped_y
// (signed q13.4, saturated) and out_clipped, which flags saturation of an
// output or of any intermediate value
// throughput: one point per clock. the pipeline runs through the
// normalising divider, one quotient bit per stage over 31 stages, and
// then through the multiplier chain of the polynomial
// configuration: cfg_wr_en, cfg_index, cfg_data write one register per
// edge, only while no point is in flight (the user's duty, not enforced);
// a zero focal length reads as one lsb, an index above seven is ignored
// reset: all in-flight points are dropped, registers return to unit focal
// lengths and zero centre and coefficients
// the receiver cannot hold results off, so there is no stall path
module lens_distortion_point_map_core
  import ldpm_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          in_pixel_x,
  input  logic [COORD_BITS-1:0]          in_pixel_y,
  output logic                           out_valid,
  output logic signed [COORD_BITS+1:0]   out_mapped_x,
  output logic signed [COORD_BITS+1:0]   out_mapped_y,
  output logic                           out_clipped,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data
);

  localparam int OB         = COORD_BITS + 2;
  localparam int NORM_SHIFT = FOCAL_FRAC + COEFF_FRAC_BITS - COORD_FRAC_BITS;
  localparam int NSTG       = 16;
  localparam int LATENCY    = Q_BITS + 3 + NSTG;
  localparam logic signed [67:0] ONE    = 68'sd1 <<< COEFF_FRAC_BITS;
  localparam logic signed [67:0] OUT_HI = (68'sd1 <<< (OB - 1)) - 68'sd1;
  localparam logic signed [67:0] OUT_LO = -OUT_HI - 68'sd1;

  // configuration registers
  logic [31:0] focal_x_r, focal_y_r;
  logic [15:0] center_x_r, center_y_r;
  logic signed [31:0] k1_r, k2_r, k3_r;
  logic [63:0] tang_r;
  logic signed [31:0] p1, p2;
  logic [31:0] wr_focal;
  logic [COORD_BITS-1:0] cx, cy;

  assign wr_focal = (cfg_data[31:0] == 32'd0) ? 32'd1 : cfg_data[31:0];
  assign p1 = tang_r[63:32];
  assign p2 = tang_r[31:0];
  assign cx = COORD_BITS'(center_x_r);
  assign cy = COORD_BITS'(center_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_RESET;
      focal_y_r  <= FOCAL_RESET;
      center_x_r <= '0;
      center_y_r <= '0;
      k1_r       <= '0;
      k2_r       <= '0;
      k3_r       <= '0;
      tang_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FOCAL_X:    focal_x_r  <= wr_focal;
        REG_FOCAL_Y:    focal_y_r  <= wr_focal;
        REG_CENTER_X:   center_x_r <= cfg_data[15:0];
        REG_CENTER_Y:   center_y_r <= cfg_data[15:0];
        REG_RADIAL_K1:  k1_r       <= cfg_data[31:0];
        REG_RADIAL_K2:  k2_r       <= cfg_data[31:0];
        REG_RADIAL_K3:  k3_r       <= cfg_data[31:0];
        REG_TANGENTIAL: tang_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                  in_fire;
  logic                  in_vld_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= in_pixel_x;
    py_r <= in_pixel_y;
  end

  // normalisation
  norm_t nx, ny;

  ldpm_norm_div #(.COORD_BITS(COORD_BITS), .NORM_SHIFT(NORM_SHIFT)) u_div_x (
    .clk(clk), .rst_n(rst_n), .in_valid(in_vld_r), .in_pixel(px_r),
    .in_center(cx), .focal(focal_x_r), .norm(nx)
  );

  ldpm_norm_div #(.COORD_BITS(COORD_BITS), .NORM_SHIFT(NORM_SHIFT)) u_div_y (
    .clk(clk), .rst_n(rst_n), .in_valid(in_vld_r), .in_pixel(py_r),
    .in_center(cy), .focal(focal_y_r), .norm(ny)
  );

  // polynomial pipeline
  logic [NSTG-1:0] vld_r;
  logic            c_r [1:NSTG];
  logic signed [31:0] x_r [1:10];
  logic signed [31:0] y_r [1:10];

  logic signed [63:0] pxx_1_r, pyy_1_r, pxy_1_r;
  logic signed [31:0] x2_2_r, y2_2_r, xy_2_r;
  logic signed [31:0] r2_3_r, x2_3_r, y2_3_r, xy_3_r;
  logic signed [63:0] pr4_4_r, pk1_4_r, pp1xy_4_r, pp2xy_4_r;
  logic signed [31:0] ax_4_r, ay_4_r, r2_4_r;
  logic signed [31:0] r4_5_r, k1r2_5_r, p1xy_5_r, p2xy_5_r, r2_5_r;
  logic signed [63:0] pp2ax_5_r, pp1ay_5_r;
  logic signed [63:0] pr6_6_r, pk2_6_r;
  logic signed [31:0] p2ax_6_r, p1ay_6_r, k1r2_6_r, p1xy_6_r, p2xy_6_r;
  logic signed [31:0] r6_7_r, k2r4_7_r, tx_7_r, ty_7_r, k1r2_7_r;
  logic signed [63:0] pk3_8_r;
  logic signed [31:0] k1r2_8_r, k2r4_8_r, tx_8_r, ty_8_r;
  logic signed [31:0] k3r6_9_r, k1r2_9_r, k2r4_9_r, tx_9_r, ty_9_r;
  logic signed [31:0] scale_10_r, tx_10_r, ty_10_r;
  logic signed [63:0] pxs_11_r, pys_11_r;
  logic signed [31:0] tx_11_r, ty_11_r;
  logic signed [31:0] xs_12_r, ys_12_r, tx_12_r, ty_12_r;
  logic signed [31:0] xb_13_r, yb_13_r;
  logic signed [64:0] pfx_14_r, pfy_14_r;
  logic signed [67:0] rx_15_r, ry_15_r;
  logic signed [OB-1:0] mx_16_r, my_16_r;

  sq_t x2_s, y2_s, xy_s, r2_s, ax_s, ay_s;
  sq_t r4_s, k1r2_s, p1xy_s, p2xy_s, p2ax_s, p1ay_s;
  sq_t r6_s, k2r4_s, tx_s, ty_s, k3r6_s, scale_s;
  sq_t xs_s, ys_s, xb_s, yb_s;
  logic signed [67:0] sx, sy;
  logic signed [OB-1:0] mx_nxt, my_nxt;
  logic mx_clip, my_clip;

  always_comb begin
    x2_s    = rsat(68'(pxx_1_r), COEFF_FRAC_BITS);
    y2_s    = rsat(68'(pyy_1_r), COEFF_FRAC_BITS);
    xy_s    = rsat(68'(pxy_1_r), COEFF_FRAC_BITS);
    r2_s    = sat32(68'(x2_2_r) + 68'(y2_2_r));
    ax_s    = sat32(68'(r2_3_r) + (68'(x2_3_r) <<< 1));
    ay_s    = sat32(68'(r2_3_r) + (68'(y2_3_r) <<< 1));
    r4_s    = rsat(68'(pr4_4_r), COEFF_FRAC_BITS);
    k1r2_s  = rsat(68'(pk1_4_r), COEFF_FRAC_BITS);
    p1xy_s  = rsat(68'(pp1xy_4_r), COEFF_FRAC_BITS);
    p2xy_s  = rsat(68'(pp2xy_4_r), COEFF_FRAC_BITS);
    p2ax_s  = rsat(68'(pp2ax_5_r), COEFF_FRAC_BITS);
    p1ay_s  = rsat(68'(pp1ay_5_r), COEFF_FRAC_BITS);
    r6_s    = rsat(68'(pr6_6_r), COEFF_FRAC_BITS);
    k2r4_s  = rsat(68'(pk2_6_r), COEFF_FRAC_BITS);
    tx_s    = sat32((68'(p1xy_6_r) <<< 1) + 68'(p2ax_6_r));
    ty_s    = sat32(68'(p1ay_6_r) + (68'(p2xy_6_r) <<< 1));
    k3r6_s  = rsat(68'(pk3_8_r), COEFF_FRAC_BITS);
    scale_s = sat32(ONE + 68'(k1r2_9_r) + 68'(k2r4_9_r) + 68'(k3r6_9_r));
    xs_s    = rsat(68'(pxs_11_r), COEFF_FRAC_BITS);
    ys_s    = rsat(68'(pys_11_r), COEFF_FRAC_BITS);
    xb_s    = sat32(68'(xs_12_r) + 68'(tx_12_r));
    yb_s    = sat32(68'(ys_12_r) + 68'(ty_12_r));
    sx      = rx_15_r + $signed(68'(cx));
    sy      = ry_15_r + $signed(68'(cy));
    mx_clip = (sx > OUT_HI) || (sx < OUT_LO);
    my_clip = (sy > OUT_HI) || (sy < OUT_LO);
    mx_nxt  = (sx > OUT_HI) ? OB'(OUT_HI) : ((sx < OUT_LO) ? OB'(OUT_LO) : OB'(sx));
    my_nxt  = (sy > OUT_HI) ? OB'(OUT_HI) : ((sy < OUT_LO) ? OB'(OUT_LO) : OB'(sy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], nx.valid};
    end
  end

  always_ff @(posedge clk) begin
    x_r[1] <= nx.val;
    y_r[1] <= ny.val;
    for (int i = 2; i <= 10; i++) begin
      x_r[i] <= x_r[i-1];
      y_r[i] <= y_r[i-1];
    end

    pxx_1_r <= nx.val * nx.val;
    pyy_1_r <= ny.val * ny.val;
    pxy_1_r <= nx.val * ny.val;
    c_r[1]  <= nx.clip | ny.clip;

    x2_2_r <= x2_s.val;
    y2_2_r <= y2_s.val;
    xy_2_r <= xy_s.val;
    c_r[2] <= c_r[1] | x2_s.clip | y2_s.clip | xy_s.clip;

    r2_3_r <= r2_s.val;
    x2_3_r <= x2_2_r;
    y2_3_r <= y2_2_r;
    xy_3_r <= xy_2_r;
    c_r[3] <= c_r[2] | r2_s.clip;

    pr4_4_r   <= r2_3_r * r2_3_r;
    pk1_4_r   <= k1_r * r2_3_r;
    pp1xy_4_r <= p1 * xy_3_r;
    pp2xy_4_r <= p2 * xy_3_r;
    ax_4_r    <= ax_s.val;
    ay_4_r    <= ay_s.val;
    r2_4_r    <= r2_3_r;
    c_r[4]    <= c_r[3] | ax_s.clip | ay_s.clip;

    r4_5_r    <= r4_s.val;
    k1r2_5_r  <= k1r2_s.val;
    p1xy_5_r  <= p1xy_s.val;
    p2xy_5_r  <= p2xy_s.val;
    pp2ax_5_r <= p2 * ax_4_r;
    pp1ay_5_r <= p1 * ay_4_r;
    r2_5_r    <= r2_4_r;
    c_r[5]    <= c_r[4] | r4_s.clip | k1r2_s.clip | p1xy_s.clip | p2xy_s.clip;

    pr6_6_r  <= r4_5_r * r2_5_r;
    pk2_6_r  <= k2_r * r4_5_r;
    p2ax_6_r <= p2ax_s.val;
    p1ay_6_r <= p1ay_s.val;
    k1r2_6_r <= k1r2_5_r;
    p1xy_6_r <= p1xy_5_r;
    p2xy_6_r <= p2xy_5_r;
    c_r[6]   <= c_r[5] | p2ax_s.clip | p1ay_s.clip;

    r6_7_r   <= r6_s.val;
    k2r4_7_r <= k2r4_s.val;
    tx_7_r   <= tx_s.val;
    ty_7_r   <= ty_s.val;
    k1r2_7_r <= k1r2_6_r;
    c_r[7]   <= c_r[6] | r6_s.clip | k2r4_s.clip | tx_s.clip | ty_s.clip;

    pk3_8_r  <= k3_r * r6_7_r;
    k1r2_8_r <= k1r2_7_r;
    k2r4_8_r <= k2r4_7_r;
    tx_8_r   <= tx_7_r;
    ty_8_r   <= ty_7_r;
    c_r[8]   <= c_r[7];

    k3r6_9_r <= k3r6_s.val;
    k1r2_9_r <= k1r2_8_r;
    k2r4_9_r <= k2r4_8_r;
    tx_9_r   <= tx_8_r;
    ty_9_r   <= ty_8_r;
    c_r[9]   <= c_r[8] | k3r6_s.clip;

    scale_10_r <= scale_s.val;
    tx_10_r    <= tx_9_r;
    ty_10_r    <= ty_9_r;
    c_r[10]    <= c_r[9] | scale_s.clip;

    pxs_11_r <= x_r[10] * scale_10_r;
    pys_11_r <= y_r[10] * scale_10_r;
    tx_11_r  <= tx_10_r;
    ty_11_r  <= ty_10_r;
    c_r[11]  <= c_r[10];

    xs_12_r <= xs_s.val;
    ys_12_r <= ys_s.val;
    tx_12_r <= tx_11_r;
    ty_12_r <= ty_11_r;
    c_r[12] <= c_r[11] | xs_s.clip | ys_s.clip;

    xb_13_r <= xb_s.val;
    yb_13_r <= yb_s.val;
    c_r[13] <= c_r[12] | xb_s.clip | yb_s.clip;

    pfx_14_r <= xb_13_r * $signed({1'b0, focal_x_r});
    pfy_14_r <= yb_13_r * $signed({1'b0, focal_y_r});
    c_r[14]  <= c_r[13];

    rx_15_r <= rnd(68'(pfx_14_r), NORM_SHIFT);
    ry_15_r <= rnd(68'(pfy_14_r), NORM_SHIFT);
    c_r[15] <= c_r[14];

    mx_16_r <= mx_nxt;
    my_16_r <= my_nxt;
    c_r[16] <= c_r[15] | mx_clip | my_clip;
  end

  assign out_valid    = vld_r[NSTG-1];
  assign out_mapped_x = mx_16_r;
  assign out_mapped_y = my_16_r;
  assign out_clipped  = c_r[NSTG];

  // a result leaves exactly one pipeline latency after its point entered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("result without matching transaction");

  // both normalising lanes stay in step
  assert property (@(posedge clk) disable iff (!rst_n)
    nx.valid == ny.valid)
    else $error("divider lanes out of step");

  // a point accepted out of reset reaches the divider output
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |-> ##(Q_BITS + 2) nx.valid)
    else $error("point lost in divider");

endmodule

// ===== tb/sv/lens_distortion_point_map_checker.sv =====
`timescale 1ns / 100ps

module lens_distortion_point_map_checker
  import ldpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [15:0]              in_pixel_x,
  input  logic [15:0]              in_pixel_y,
  input  logic                     out_valid,
  input  logic signed [17:0]       out_mapped_x,
  input  logic signed [17:0]       out_mapped_y,
  input  logic                     out_clipped,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatch_count,
  output int                       pending_points
);

  localparam int FRAC_Q = 28;
  localparam int SHIFT_N = 40;

  typedef struct {
    logic signed [17:0] mx;
    logic signed [17:0] my;
    logic               clip;
  } mapped_point_t;

  mapped_point_t awaited_points[$];
  logic [31:0] fx_reg, fy_reg, k1_reg, k2_reg, k3_reg;
  logic [15:0] cx_reg, cy_reg;
  logic [63:0] tan_reg;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint nearest(longint v, int s);
    return floor_shift(floor_shift(v, s - 1) + 1, 1);
  endfunction

  function automatic longint clamp32(longint v, inout bit c);
    if (v > 64'sd2147483647) begin
      c = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      c = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, inout bit c);
    return clamp32(nearest(a * b, FRAC_Q), c);
  endfunction

  function automatic longint divide_norm(longint d, longint unsigned f, inout bit c);
    longint unsigned n, q, r;
    n = (d < 0) ? longint'(-d) : d;
    q = n / f;
    r = n % f;
    if (q > 64'd2147483647) begin
      c = 1;
      q = 64'd2147483647;
    end else begin
      for (int i = 0; i < SHIFT_N; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= f) begin
          r = r - f;
          q = q | 1;
        end
        if (q > 64'd2147483647) begin
          c = 1;
          q = 64'd2147483647;
          break;
        end
      end
    end
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [17:0] back_to_pixel(longint v, longint f, longint ctr,
                                                       inout bit c);
    longint p;
    p = nearest(v * f, SHIFT_N) + ctr;
    if (p > 131071) begin
      c = 1;
      p = 131071;
    end else if (p < -131072) begin
      c = 1;
      p = -131072;
    end
    return p[17:0];
  endfunction

  function automatic mapped_point_t undistort_point(logic [15:0] px, logic [15:0] py);
    mapped_point_t res;
    bit c;
    longint fx, fy, k1, k2, k3, p1, p2, one;
    longint x, y, x2, y2, xy, r2, r4, r6, scl, tx, ty, xb, yb;
    c = 0;
    fx = (fx_reg == 0) ? 1 : longint'(fx_reg);
    fy = (fy_reg == 0) ? 1 : longint'(fy_reg);
    k1 = longint'(signed'(k1_reg));
    k2 = longint'(signed'(k2_reg));
    k3 = longint'(signed'(k3_reg));
    p1 = longint'(signed'(tan_reg[63:32]));
    p2 = longint'(signed'(tan_reg[31:0]));
    one = 64'sd1 <<< FRAC_Q;
    x = divide_norm(longint'(px) - longint'(cx_reg), fx, c);
    y = divide_norm(longint'(py) - longint'(cy_reg), fy, c);
    x2 = qmul(x, x, c);
    y2 = qmul(y, y, c);
    xy = qmul(x, y, c);
    r2 = clamp32(x2 + y2, c);
    r4 = qmul(r2, r2, c);
    r6 = qmul(r4, r2, c);
    scl = clamp32(one + qmul(k1, r2, c) + qmul(k2, r4, c) + qmul(k3, r6, c), c);
    tx = clamp32(2 * qmul(p1, xy, c) + qmul(p2, clamp32(r2 + 2 * x2, c), c), c);
    ty = clamp32(qmul(p1, clamp32(r2 + 2 * y2, c), c) + 2 * qmul(p2, xy, c), c);
    xb = clamp32(qmul(x, scl, c) + tx, c);
    yb = clamp32(qmul(y, scl, c) + ty, c);
    res.mx = back_to_pixel(xb, fx, longint'(cx_reg), c);
    res.my = back_to_pixel(yb, fy, longint'(cy_reg), c);
    res.clip = c;
    return res;
  endfunction

  assign pending_points = awaited_points.size();

  always @(posedge clk) begin
    mapped_point_t e;
    if (!rst_n) begin
      awaited_points.delete();
      mismatch_count <= 0;
      fx_reg <= FOCAL_RESET;
      fy_reg <= FOCAL_RESET;
      cx_reg <= '0;
      cy_reg <= '0;
      k1_reg <= '0;
      k2_reg <= '0;
      k3_reg <= '0;
      tan_reg <= '0;
    end else begin
      if (out_valid) begin
        if (awaited_points.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result x=%0d y=%0d clip=%0b",
                     out_mapped_x, out_mapped_y, out_clipped);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = awaited_points.pop_front();
          if (e.mx !== out_mapped_x || e.my !== out_mapped_y || e.clip !== out_clipped) begin
            if (mismatch_count < 10)
              $display("mismatch: expected x=%0d y=%0d clip=%0b, got x=%0d y=%0d clip=%0b",
                       e.mx, e.my, e.clip, out_mapped_x, out_mapped_y, out_clipped);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy)
        awaited_points.insert(awaited_points.size(),
                              undistort_point(in_pixel_x, in_pixel_y));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FOCAL_X:    fx_reg <= cfg_data[31:0];
          REG_FOCAL_Y:    fy_reg <= cfg_data[31:0];
          REG_CENTER_X:   cx_reg <= cfg_data[15:0];
          REG_CENTER_Y:   cy_reg <= cfg_data[15:0];
          REG_RADIAL_K1:  k1_reg <= cfg_data[31:0];
          REG_RADIAL_K2:  k2_reg <= cfg_data[31:0];
          REG_RADIAL_K3:  k3_reg <= cfg_data[31:0];
          REG_TANGENTIAL: tan_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/lens_distortion_point_map_core_test.sv =====
`timescale 1ns / 100ps

module lens_distortion_point_map_core_test;
  import ldpm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_pixel_x = '0;
  logic [15:0] in_pixel_y = '0;
  logic out_valid;
  logic signed [17:0] out_mapped_x, out_mapped_y;
  logic out_clipped;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int mismatch_count, pending_points;
  int idle_pct;

  always #5 clk = ~clk;

  lens_distortion_point_map_core dut (.*);

  lens_distortion_point_map_checker checker_i (.*);

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // waits for the pipeline to drain before a register write
  task automatic drain_points();
    while (pending_points != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one transaction, start held across back-to-back points
  task automatic send_point(logic [15:0] px, logic [15:0] py);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_pixel_x <= px;
    in_pixel_y <= py;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] small_coeff();
    return 32'($signed($urandom_range(0, 2**24)) - 2**23);
  endfunction

  task automatic random_points(int n);
    logic [15:0] px, py;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        px = 16'($urandom);
        py = 16'($urandom);
      end else begin
        px = 16'($urandom_range(0, 20000));
        py = 16'($urandom_range(0, 20000));
      end
      send_point(px, py);
    end
    end_burst();
  endtask

  task automatic apply_setting(int s);
    drain_points();
    case (s)
      0: begin
        write_reg(REG_FOCAL_X, 64'hFFFF_FFFF);
        write_reg(REG_FOCAL_Y, 64'h0);
        write_reg(REG_CENTER_X, 64'hFFFF);
        write_reg(REG_CENTER_Y, 64'h0);
        write_reg(REG_RADIAL_K1, 64'h7FFF_FFFF);
        write_reg(REG_RADIAL_K2, 64'h8000_0000);
        write_reg(REG_RADIAL_K3, 64'h7FFF_FFFF);
        write_reg(REG_TANGENTIAL, 64'h8000_0000_7FFF_FFFF);
      end
      1: begin
        write_reg(REG_FOCAL_X, 64'd800 << 16);
        write_reg(REG_FOCAL_Y, 64'd780 << 16);
        write_reg(REG_CENTER_X, 64'd640 << 4);
        write_reg(REG_CENTER_Y, 64'd480 << 4);
        write_reg(REG_RADIAL_K1, {32'h0, small_coeff()});
        write_reg(REG_RADIAL_K2, {32'h0, small_coeff()});
        write_reg(REG_RADIAL_K3, {32'h0, small_coeff()});
        write_reg(REG_TANGENTIAL, {small_coeff(), small_coeff()});
        write_reg(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      default: begin
        write_reg(REG_FOCAL_X, {32'h0, 32'($urandom_range(1, 32'h0400_0000))});
        write_reg(REG_FOCAL_Y, {32'h0, 32'($urandom_range(1, 32'h0400_0000))});
        write_reg(REG_CENTER_X, {48'h0, 16'($urandom)});
        write_reg(REG_CENTER_Y, {48'h0, 16'($urandom)});
        write_reg(REG_RADIAL_K1, {32'h0, $urandom});
        write_reg(REG_RADIAL_K2, {32'h0, small_coeff()});
        write_reg(REG_RADIAL_K3, {32'h0, small_coeff()});
        write_reg(REG_TANGENTIAL, {$urandom, $urandom});
      end
    endcase
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    idle_pct = 26;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: corners and mixed points with reset configuration
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'hFFFF);
    send_point(16'h5555, 16'hAAAA);
    send_point(16'hAAAA, 16'h5555);
    end_burst();
    apply_setting(0);
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'h0001, 16'hFFFE);
    send_point(16'h8000, 16'h7FFF);
    end_burst();
    apply_setting(1);
    send_point(16'd640 << 4, 16'd480 << 4);
    send_point(16'h0000, 16'h0000);
    send_point(16'd1279 << 4, 16'd959 << 4);
    send_point(16'hFFFF, 16'hFFFF);
    end_burst();
    // random phases, the second without any idling
    random_points(300);
    idle_pct = 0;
    random_points(250);
    idle_pct = 26;
    apply_setting(2);
    random_points(150);
    apply_setting(1);
    random_points(250);
    apply_setting(0);
    random_points(60);
    apply_setting(3);
    random_points(120);
    drain_points();
    if (mismatch_count == 0 && pending_points == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
